>>> sv/health_report_table_defines.svh
// Assertion macros for the health report table.
`ifndef HEALTH_REPORT_TABLE_DEFINES_SVH
`define HEALTH_REPORT_TABLE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define HRT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define HRT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/hrt_pkg.sv
// Shared types, constants and helpers of the health report table.
package hrt_pkg;

  localparam int NUM_SUBSYSTEMS = 8;
  localparam int IDX_W   = (NUM_SUBSYSTEMS > 1) ? $clog2(NUM_SUBSYSTEMS) : 1;
  localparam int SUB_W   = 6;
  localparam int LEVEL_W = 2;
  localparam int CODE_W  = 4;
  localparam int STAMP_W = 64;

  localparam logic [IDX_W-1:0] LAST_IDX    = IDX_W'(NUM_SUBSYSTEMS - 1);
  localparam logic [SUB_W:0]   NUM_SUB_EXT = (SUB_W + 1)'(NUM_SUBSYSTEMS);

  localparam logic [STAMP_W-1:0] STALE_LIMIT_RESET = STAMP_W'(10000);

  // actions and result kinds
  localparam logic ACT_REPORT   = 1'b0;
  localparam logic ACT_SNAPSHOT = 1'b1;
  localparam logic KIND_ACK     = 1'b0;
  localparam logic KIND_ENTRY   = 1'b1;

  // levels, in severity order
  localparam logic [LEVEL_W-1:0] LVL_HEALTHY  = 2'd0;
  localparam logic [LEVEL_W-1:0] LVL_UNKNOWN  = 2'd1;
  localparam logic [LEVEL_W-1:0] LVL_DEGRADED = 2'd2;
  localparam logic [LEVEL_W-1:0] LVL_FAILED   = 2'd3;

  // status codes
  localparam logic [CODE_W-1:0] CODE_NOT_INIT     = 4'd0;
  localparam logic [CODE_W-1:0] CODE_OK           = 4'd1;
  localparam logic [CODE_W-1:0] CODE_UNPROV       = 4'd2;
  localparam logic [CODE_W-1:0] CODE_CONN_TIMEOUT = 4'd3;
  localparam logic [CODE_W-1:0] CODE_LINK_LOST    = 4'd4;
  localparam logic [CODE_W-1:0] CODE_BAD_CFG      = 4'd5;
  localparam logic [CODE_W-1:0] CODE_AUTH_REJ     = 4'd6;
  localparam logic [CODE_W-1:0] CODE_ALLOC_FAIL   = 4'd7;
  localparam logic [CODE_W-1:0] CODE_STALE        = 4'd8;
  localparam logic [CODE_W-1:0] CODE_TS_INVALID   = 4'd9;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic [CODE_W-1:0]  code;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    entry_t           entry;
  } store_wr_t;

  // level that a code implies
  function automatic logic [LEVEL_W-1:0] level_for_code(input logic [CODE_W-1:0] c);
    logic [LEVEL_W-1:0] l;
    case (c)
      CODE_OK: l = LVL_HEALTHY;
      CODE_UNPROV, CODE_CONN_TIMEOUT, CODE_LINK_LOST: l = LVL_DEGRADED;
      CODE_BAD_CFG, CODE_AUTH_REJ, CODE_ALLOC_FAIL: l = LVL_FAILED;
      default: l = LVL_UNKNOWN;
    endcase
    return l;
  endfunction

endpackage

>>> sv/hrt_req_if.sv
// Request channel: report or snapshot items.
interface hrt_req_if import hrt_pkg::*;;
  logic               valid;
  logic               ready;
  logic               action;
  logic [SUB_W-1:0]   subsystem;
  logic [LEVEL_W-1:0] level;
  logic [CODE_W-1:0]  code;
  logic [STAMP_W-1:0] stamp_ms;
  logic [STAMP_W-1:0] now_ms;

  modport source (output valid, action, subsystem, level, code, stamp_ms, now_ms,
                  input ready);
  modport sink   (input valid, action, subsystem, level, code, stamp_ms, now_ms,
                  output ready);
endinterface

>>> sv/hrt_rsp_if.sv
// Response channel: acknowledgements and snapshot entries.
interface hrt_rsp_if import hrt_pkg::*;;
  logic               valid;
  logic               ready;
  logic               kind;
  logic               accepted;
  logic [SUB_W-1:0]   entry_index;
  logic [LEVEL_W-1:0] entry_level;
  logic [CODE_W-1:0]  entry_code;
  logic [STAMP_W-1:0] entry_stamp_ms;
  logic [LEVEL_W-1:0] overall_level;
  logic               last;

  modport source (output valid, kind, accepted, entry_index, entry_level, entry_code,
                  entry_stamp_ms, overall_level, last, input ready);
  modport sink   (input valid, kind, accepted, entry_index, entry_level, entry_code,
                  entry_stamp_ms, overall_level, last, output ready);
endinterface

>>> sv/hrt_cfg_if.sv
// Configuration write channel: stale limit.
interface hrt_cfg_if import hrt_pkg::*;;
  logic               valid;
  logic               ready;
  logic [STAMP_W-1:0] stale_limit_ms;

  modport source (output valid, stale_limit_ms, input ready);
  modport sink   (input valid, stale_limit_ms, output ready);
endinterface

>>> sv/hrt_sub_unit.sv
// Shared 64-bit subtract/compare unit.
module hrt_sub_unit import hrt_pkg::*; (
  input  logic [STAMP_W-1:0] a,
  input  logic [STAMP_W-1:0] b,
  output logic [STAMP_W-1:0] diff,
  output logic               borrow  // a < b
);

  logic [STAMP_W:0] full;

  assign full   = {1'b0, a} - {1'b0, b};
  assign diff   = full[STAMP_W-1:0];
  assign borrow = full[STAMP_W];

endmodule

>>> sv/hrt_store.sv
// Per-subsystem entry table.
module hrt_store import hrt_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  store_wr_t        wr,
  input  logic [IDX_W-1:0] rd_addr,
  output entry_t           rd
);

  entry_t entries [NUM_SUBSYSTEMS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_SUBSYSTEMS; i++) begin
        entries[i] <= '{level: LVL_UNKNOWN, code: CODE_NOT_INIT, stamp: '0};
      end
    end else if (wr.en) begin
      entries[wr.addr] <= wr.entry;
    end
  end

  assign rd = entries[rd_addr];

endmodule

>>> sv/health_report_table.sv
// Top level of the health report table: sequencer, output register, config.
//
//  channel | dir | payload                                              | handshake
//  --------+-----+------------------------------------------------------+----------
//  req     | in  | action, subsystem, level, code, stamp_ms, now_ms     | valid/ready
//  rsp     | out | kind, accepted, entry_index, entry_level, entry_code,| valid/ready
//          |     | entry_stamp_ms, overall_level, last                  |
//  cfg     | in  | stale_limit_ms                                       | valid/ready
//
// Report: after accept, R_TIME and R_AGE make two passes through the shared 64-bit
//   subtractor (time check, age check); R_ACK loads the ack in the output register.
// Snapshot: each entry takes two subtractor passes (S_TIME future check, S_STALE
//   stale check) and one load in S_EMIT, for every entry of the table.
// req is ready only in idle; the last result may still sit in the output
//   register, so the next item is taken while it waits. rsp stalls hold the
//   sequencer in its load state. cfg is always ready.
// Reset (rst, synchronous): entries to unknown/not_init/0, stale limit 10000 ms.
`include "health_report_table_defines.svh"

module health_report_table import hrt_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  hrt_req_if.sink   req,
  hrt_rsp_if.source rsp,
  hrt_cfg_if.sink   cfg
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_R_TIME,   // stamp after now?
    ST_R_AGE,    // stamp older than stored?
    ST_R_ACK,    // store and acknowledge
    ST_S_TIME,   // entry stamp after now? keep now - stamp
    ST_S_STALE,  // age beyond stale limit?
    ST_S_EMIT    // load entry result
  } state_t;

  state_t             state;
  logic [STAMP_W-1:0] stale_limit;
  logic [STAMP_W-1:0] now_q;
  logic [STAMP_W-1:0] stamp_q;
  logic [LEVEL_W-1:0] lvl_q;
  logic [CODE_W-1:0]  code_q;
  logic [IDX_W-1:0]   idx;
  logic               ok;
  logic [STAMP_W-1:0] age;
  logic               future;
  logic               stale;
  logic [LEVEL_W-1:0] worst;
  logic               any;

  // shared unit operands
  logic [STAMP_W-1:0] op_a;
  logic [STAMP_W-1:0] op_b;
  logic [STAMP_W-1:0] sub_diff;
  logic               sub_borrow;

  entry_t             rd;
  store_wr_t          wr;
  logic               rsp_free;
  logic               rsp_load;

  // effective view of the current snapshot entry
  logic               reported;
  logic [LEVEL_W-1:0] eff_level;
  logic [CODE_W-1:0]  eff_code;
  logic [LEVEL_W-1:0] worst_next;
  logic               any_next;

  logic               req_ok;

  assign req.ready = (state == ST_IDLE);
  assign cfg.ready = 1'b1;
  assign rsp_free  = !rsp.valid || rsp.ready;
  // output register takes a new item this cycle
  assign rsp_load  = rsp_free && ((state == ST_R_ACK) || (state == ST_S_EMIT));

  // range and level/code consistency are known at accept
  assign req_ok = ({1'b0, req.subsystem} < NUM_SUB_EXT) &&
                  (req.level == level_for_code(req.code));

  always_comb begin
    case (state)
      ST_R_AGE: begin
        op_a = stamp_q;
        op_b = rd.stamp;
      end
      ST_S_TIME: begin
        op_a = now_q;
        op_b = rd.stamp;
      end
      ST_S_STALE: begin
        op_a = stale_limit;
        op_b = age;
      end
      default: begin
        op_a = now_q;
        op_b = stamp_q;
      end
    endcase
  end

  hrt_sub_unit u_sub (
    .a      (op_a),
    .b      (op_b),
    .diff   (sub_diff),
    .borrow (sub_borrow)
  );

  assign wr.en    = (state == ST_R_ACK) && rsp_free && ok;
  assign wr.addr  = idx;
  assign wr.entry = '{level: lvl_q, code: code_q, stamp: stamp_q};

  hrt_store u_store (
    .clk     (clk),
    .rst     (rst),
    .wr      (wr),
    .rd_addr (idx),
    .rd      (rd)
  );

  always_comb begin
    reported  = (rd.code != CODE_NOT_INIT);
    eff_level = rd.level;
    eff_code  = rd.code;
    if (reported && future) begin
      eff_level = LVL_UNKNOWN;
      eff_code  = CODE_TS_INVALID;
    end else if (reported && stale) begin
      eff_level = LVL_UNKNOWN;
      eff_code  = CODE_STALE;
    end
    worst_next = (reported && (eff_level > worst)) ? eff_level : worst;
    any_next   = any || reported;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      rsp.valid   <= 1'b0;
      stale_limit <= STALE_LIMIT_RESET;
    end else begin
      if (cfg.valid && cfg.ready) begin
        stale_limit <= cfg.stale_limit_ms;
      end
      // drained and not refilled this cycle
      if (rsp.valid && rsp.ready && !rsp_load) begin
        rsp.valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (req.valid) begin
            now_q   <= req.now_ms;
            stamp_q <= req.stamp_ms;
            lvl_q   <= req.level;
            code_q  <= req.code;
            ok      <= req_ok;
            worst   <= LVL_HEALTHY;
            any     <= 1'b0;
            if (req.action == ACT_SNAPSHOT) begin
              idx   <= '0;
              state <= ST_S_TIME;
            end else begin
              idx   <= req.subsystem[IDX_W-1:0];
              state <= ST_R_TIME;
            end
          end
        end
        ST_R_TIME: begin
          if (sub_borrow) begin
            ok <= 1'b0;
          end
          state <= ST_R_AGE;
        end
        ST_R_AGE: begin
          // an older stamp only loses against an entry already reported
          if ((rd.code != CODE_NOT_INIT) && sub_borrow) begin
            ok <= 1'b0;
          end
          state <= ST_R_ACK;
        end
        ST_R_ACK: begin
          if (rsp_free) begin
            rsp.valid          <= 1'b1;
            rsp.kind           <= KIND_ACK;
            rsp.accepted       <= ok;
            rsp.entry_index    <= '0;
            rsp.entry_level    <= LVL_HEALTHY;
            rsp.entry_code     <= CODE_NOT_INIT;
            rsp.entry_stamp_ms <= '0;
            rsp.overall_level  <= LVL_HEALTHY;
            rsp.last           <= 1'b1;
            state              <= ST_IDLE;
          end
        end
        ST_S_TIME: begin
          future <= sub_borrow;
          age    <= sub_diff;
          state  <= ST_S_STALE;
        end
        ST_S_STALE: begin
          stale <= sub_borrow;
          state <= ST_S_EMIT;
        end
        ST_S_EMIT: begin
          if (rsp_free) begin
            rsp.valid          <= 1'b1;
            rsp.kind           <= KIND_ENTRY;
            rsp.accepted       <= 1'b0;
            rsp.entry_index    <= SUB_W'(idx);
            rsp.entry_level    <= eff_level;
            rsp.entry_code     <= eff_code;
            rsp.entry_stamp_ms <= rd.stamp;
            worst              <= worst_next;
            any                <= any_next;
            if (idx == LAST_IDX) begin
              rsp.overall_level <= any_next ? worst_next : LVL_UNKNOWN;
              rsp.last          <= 1'b1;
              state             <= ST_IDLE;
            end else begin
              rsp.overall_level <= LVL_HEALTHY;
              rsp.last          <= 1'b0;
              idx               <= idx + 1'b1;
              state             <= ST_S_TIME;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // an ack is always a single, final item
  `HRT_ASSERT_IMP(a_ack_single, rsp.valid && (rsp.kind == KIND_ACK), rsp.last && (rsp.entry_index == '0), "ack must be last with index zero")
  // a snapshot closes on the highest entry
  `HRT_ASSERT_IMP(a_snap_last_idx, rsp.valid && (rsp.kind == KIND_ENTRY) && rsp.last, rsp.entry_index == SUB_W'(NUM_SUBSYSTEMS - 1), "snapshot ended early")
  // an emit with a free output register always produces an entry
  `HRT_ASSERT_NXT(a_emit_loads, (state == ST_S_EMIT) && rsp_free, rsp.valid && (rsp.kind == KIND_ENTRY), "entry not loaded")

endmodule

>>> tb/tb.sv
// Testbench of the health report table: a directed table, then random reports and snapshots.
module tb;
  import hrt_pkg::*;

  // Run limits. The longest quiet stretch of a correct run is the long
  // output hold plus one full snapshot, so the watchdog sits well above it.
  localparam int WATCHDOG_LIMIT  = 3000;
  localparam int HOLD_CYCLES     = 300;
  localparam int DRAIN_CYCLES    = 40;
  localparam int ITEMS_PER_PHASE = 40;
  localparam int NUM_PHASES      = 5;
  localparam int MAX_SHOWN       = 10;

  // Codes ten to fifteen have no name in the package.
  localparam logic [CODE_W-1:0]  CODE_SPARE_LO = 4'd10;
  localparam logic [CODE_W-1:0]  CODE_SPARE_HI = 4'd15;
  localparam logic [STAMP_W-1:0] STAMP_MAX     = '1;

  // How a directed row is checked: by the shadow table, or against an
  // outcome that is plain from the rules.
  typedef enum logic [1:0] {BY_MODEL, ACK_STORED, ACK_REFUSED, BLANK_SNAPSHOT} check_t;

  typedef struct packed {
    logic               action;
    logic [SUB_W-1:0]   subsystem;
    logic [LEVEL_W-1:0] level;
    logic [CODE_W-1:0]  code;
    logic [STAMP_W-1:0] stamp_ms;
    logic [STAMP_W-1:0] now_ms;
  } item_t;

  typedef struct packed {
    item_t  it;
    check_t chk;
  } plan_row_t;

  typedef struct packed {
    logic               kind;
    logic               accepted;
    logic [SUB_W-1:0]   entry_index;
    logic [LEVEL_W-1:0] entry_level;
    logic [CODE_W-1:0]  entry_code;
    logic [STAMP_W-1:0] entry_stamp_ms;
    logic [LEVEL_W-1:0] overall_level;
    logic               last;
  } result_t;

  logic clk;
  logic rst;

  hrt_req_if req_ch ();
  hrt_rsp_if rsp_ch ();
  hrt_cfg_if cfg_ch ();

  health_report_table dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  // Shadow copy of the table and of the stale limit.
  logic [LEVEL_W-1:0] shadow_level [NUM_SUBSYSTEMS];
  logic [CODE_W-1:0]  shadow_code  [NUM_SUBSYSTEMS];
  logic [STAMP_W-1:0] shadow_stamp [NUM_SUBSYSTEMS];
  logic [STAMP_W-1:0] shadow_stale_limit;

  result_t step_out [NUM_SUBSYSTEMS];  // results of the item just taken
  result_t due_results [$];            // results still to come, oldest first

  int faults;
  int idle_cycles;
  bit brisk;                           // no idling on either side
  bit hold_rsp;                        // asks the receiver for one long hold
  logic [STAMP_W-1:0] now_base;        // running observation time of the random part

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Level that a code pins a report to.
  function automatic logic [LEVEL_W-1:0] implied_level(input logic [CODE_W-1:0] c);
    case (c)
      CODE_OK: return LVL_HEALTHY;
      CODE_UNPROV, CODE_CONN_TIMEOUT, CODE_LINK_LOST: return LVL_DEGRADED;
      CODE_BAD_CFG, CODE_AUTH_REJ, CODE_ALLOC_FAIL: return LVL_FAILED;
      default: return LVL_UNKNOWN;
    endcase
  endfunction

  // Applies one item to the shadow table; fills step_out and returns the count.
  function automatic int advance_health_table(input item_t it);
    logic               stored;
    logic               any;
    logic [IDX_W-1:0]   slot;
    logic [LEVEL_W-1:0] worst;
    logic [LEVEL_W-1:0] lvl;
    logic [CODE_W-1:0]  cd;
    logic [STAMP_W-1:0] st;
    result_t            r;
    int                 i;
    if (it.action == ACT_REPORT) begin
      slot   = it.subsystem[IDX_W-1:0];
      stored = (it.subsystem < NUM_SUBSYSTEMS);
      if (stored && it.level != implied_level(it.code))
        stored = 1'b0;
      if (stored && it.stamp_ms > it.now_ms)
        stored = 1'b0;
      // an entry reported before refuses anything older than it
      if (stored && shadow_code[slot] != CODE_NOT_INIT && it.stamp_ms < shadow_stamp[slot])
        stored = 1'b0;
      if (stored) begin
        shadow_level[slot] = it.level;
        shadow_code[slot]  = it.code;
        shadow_stamp[slot] = it.stamp_ms;
      end
      r          = '0;
      r.kind     = KIND_ACK;
      r.accepted = stored;
      r.last     = 1'b1;
      step_out[0] = r;
      return 1;
    end
    any   = 1'b0;
    worst = LVL_HEALTHY;
    for (i = 0; i < NUM_SUBSYSTEMS; i++) begin
      lvl = shadow_level[i];
      cd  = shadow_code[i];
      st  = shadow_stamp[i];
      if (cd != CODE_NOT_INIT) begin
        any = 1'b1;
        // future stamp wins over age
        if (st > it.now_ms) begin
          lvl = LVL_UNKNOWN;
          cd  = CODE_TS_INVALID;
        end else if (it.now_ms - st > shadow_stale_limit) begin
          lvl = LVL_UNKNOWN;
          cd  = CODE_STALE;
        end
        if (lvl > worst)
          worst = lvl;
      end
      r                = '0;
      r.kind           = KIND_ENTRY;
      r.entry_index    = SUB_W'(i);
      r.entry_level    = lvl;
      r.entry_code     = cd;
      r.entry_stamp_ms = st;
      if (i == NUM_SUBSYSTEMS - 1) begin
        r.overall_level = any ? worst : LVL_UNKNOWN;
        r.last          = 1'b1;
      end
      step_out[i] = r;
    end
    return NUM_SUBSYSTEMS;
  endfunction

  // Hand-written outcomes of the plain directed rows.
  task automatic queue_fixed_results(input check_t chk);
    result_t r;
    int      i;
    if (chk == BLANK_SNAPSHOT) begin
      for (i = 0; i < NUM_SUBSYSTEMS; i++) begin
        r               = '0;
        r.kind          = KIND_ENTRY;
        r.entry_index   = SUB_W'(i);
        r.entry_level   = LVL_UNKNOWN;
        r.entry_code    = CODE_NOT_INIT;
        r.overall_level = (i == NUM_SUBSYSTEMS - 1) ? LVL_UNKNOWN : LVL_HEALTHY;
        r.last          = (i == NUM_SUBSYSTEMS - 1);
        due_results.push_back(r);
      end
    end else begin
      r          = '0;
      r.kind     = KIND_ACK;
      r.accepted = (chk == ACK_STORED);
      r.last     = 1'b1;
      due_results.push_back(r);
    end
  endtask

  // Offers one item after a random gap and books its results once taken.
  // valid is left high on acceptance; the next call, unless its gap is zero, or a
  // drain lowers it in the same time step, so it is never lowered and raised in one step.
  task automatic send_item(input item_t it, input check_t chk);
    int gap;
    int n;
    int i;
    gap = brisk ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.action    <= it.action;
    req_ch.subsystem <= it.subsystem;
    req_ch.level     <= it.level;
    req_ch.code      <= it.code;
    req_ch.stamp_ms  <= it.stamp_ms;
    req_ch.now_ms    <= it.now_ms;
    do @(posedge clk); while (!req_ch.ready);
    n = advance_health_table(it);
    if (chk == BY_MODEL) begin
      for (i = 0; i < n; i++)
        due_results.push_back(step_out[i]);
    end else begin
      queue_fixed_results(chk);
    end
  endtask

  // Stops offering and waits until every booked result is back.
  task automatic wait_for_results();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (due_results.size() != 0);
    repeat (2) @(posedge clk);
  endtask

  // Register writes happen only with the table idle.
  task automatic set_stale_limit(input logic [STAMP_W-1:0] value);
    wait_for_results();
    cfg_ch.valid          <= 1'b1;
    cfg_ch.stale_limit_ms <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    shadow_stale_limit = value;
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic plan_row_t plan_row(input logic act, input logic [SUB_W-1:0] sub,
                                         input logic [LEVEL_W-1:0] lvl,
                                         input logic [CODE_W-1:0] cd,
                                         input logic [STAMP_W-1:0] st,
                                         input logic [STAMP_W-1:0] nw, input check_t chk);
    plan_row_t p;
    p.it.action    = act;
    p.it.subsystem = sub;
    p.it.level     = lvl;
    p.it.code      = cd;
    p.it.stamp_ms  = st;
    p.it.now_ms    = nw;
    p.chk          = chk;
    return p;
  endfunction

  // Random item: mostly well-formed reports that move time forward, some
  // snapshots at varied reference times, some near misses and pure noise.
  function automatic item_t draw_item();
    item_t it;
    int    pick;
    pick     = $urandom_range(0, 99);
    now_base = now_base + STAMP_W'($urandom_range(0, 3000));
    it.action    = ACT_REPORT;
    it.subsystem = SUB_W'($urandom);
    it.level     = LEVEL_W'($urandom);
    it.code      = CODE_W'($urandom);
    it.stamp_ms  = {$urandom, $urandom};
    it.now_ms    = {$urandom, $urandom};
    if (pick < 30) begin
      it.action = ACT_SNAPSHOT;
      case ($urandom_range(0, 3))
        0: it.now_ms = now_base;
        1: it.now_ms = now_base + STAMP_W'($urandom_range(0, 30000));
        2: it.now_ms = now_base - STAMP_W'($urandom_range(0, 20000));
        default: ;  // fully random reference time
      endcase
    end else if (pick < 92) begin
      it.subsystem = SUB_W'($urandom_range(0, NUM_SUBSYSTEMS - 1));
      if ($urandom_range(0, 9) == 0)
        it.code = CODE_W'($urandom_range(CODE_SPARE_LO, CODE_SPARE_HI));
      else
        it.code = CODE_W'($urandom_range(CODE_NOT_INIT, CODE_TS_INVALID));
      it.level  = implied_level(it.code);
      it.now_ms = now_base;
      if (pick < 85)
        it.stamp_ms = now_base - STAMP_W'($urandom_range(0, 800));
      else  // near miss: slightly in the future or older than the entry
        it.stamp_ms = now_base + STAMP_W'($urandom_range(0, 3))
                      - STAMP_W'($urandom_range(0, 6000));
    end
    return it;
  endfunction

  // Stimulus: reset, directed table, then random phases under several limits.
  initial begin
    plan_row_t          plan [$];
    logic [STAMP_W-1:0] lim;
    int                 p;
    int                 k;
    rst                   <= 1'b1;
    req_ch.valid          <= 1'b0;
    req_ch.action         <= ACT_REPORT;
    req_ch.subsystem      <= '0;
    req_ch.level          <= '0;
    req_ch.code           <= CODE_NOT_INIT;
    req_ch.stamp_ms       <= '0;
    req_ch.now_ms         <= '0;
    cfg_ch.valid          <= 1'b0;
    cfg_ch.stale_limit_ms <= '0;
    brisk    = 1'b0;
    hold_rsp = 1'b0;
    now_base = 64'd1000;
    for (k = 0; k < NUM_SUBSYSTEMS; k++) begin
      shadow_level[k] = LVL_UNKNOWN;
      shadow_code[k]  = CODE_NOT_INIT;
      shadow_stamp[k] = '0;
    end
    shadow_stale_limit = STALE_LIMIT_RESET;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // fresh table, then every rule of a report in turn
    plan.push_back(plan_row(ACT_SNAPSHOT, 0, LVL_HEALTHY, CODE_NOT_INIT, 0, 0,
                            BLANK_SNAPSHOT));
    plan.push_back(plan_row(ACT_REPORT, 0, LVL_HEALTHY, CODE_OK, 100, 200, ACK_STORED));
    plan.push_back(plan_row(ACT_REPORT, 8, LVL_HEALTHY, CODE_OK, 100, 200, ACK_REFUSED));
    plan.push_back(plan_row(ACT_REPORT, 63, LVL_HEALTHY, CODE_OK, 100, 200, ACK_REFUSED));
    // level not the one the code implies
    plan.push_back(plan_row(ACT_REPORT, 1, LVL_DEGRADED, CODE_OK, 100, 200, ACK_REFUSED));
    // stamp after the observation time, then equal to it
    plan.push_back(plan_row(ACT_REPORT, 1, LVL_DEGRADED, CODE_LINK_LOST, 500, 400,
                            ACK_REFUSED));
    plan.push_back(plan_row(ACT_REPORT, 1, LVL_DEGRADED, CODE_LINK_LOST, 400, 400,
                            ACK_STORED));
    // older than the stored entry, then exactly as old
    plan.push_back(plan_row(ACT_REPORT, 0, LVL_HEALTHY, CODE_OK, 50, 300, ACK_REFUSED));
    plan.push_back(plan_row(ACT_REPORT, 0, LVL_HEALTHY, CODE_OK, 100, 300, ACK_STORED));
    plan.push_back(plan_row(ACT_REPORT, 1, LVL_DEGRADED, CODE_CONN_TIMEOUT, 450, 460,
                            ACK_STORED));
    plan.push_back(plan_row(ACT_REPORT, 2, LVL_FAILED, CODE_BAD_CFG, 1000, 2000,
                            ACK_STORED));
    plan.push_back(plan_row(ACT_REPORT, 2, LVL_DEGRADED, CODE_UNPROV, 1500, 1500,
                            ACK_STORED));
    plan.push_back(plan_row(ACT_REPORT, 2, LVL_FAILED, CODE_ALLOC_FAIL, 1600, 1600,
                            ACK_STORED));
    plan.push_back(plan_row(ACT_REPORT, 3, LVL_FAILED, CODE_AUTH_REJ, STAMP_MAX, STAMP_MAX,
                            ACK_STORED));
    // not_init report: stored, and the entry counts as unreported again,
    // so an older stamp after it still goes in
    plan.push_back(plan_row(ACT_REPORT, 4, LVL_UNKNOWN, CODE_NOT_INIT, 5, 5, ACK_STORED));
    plan.push_back(plan_row(ACT_REPORT, 4, LVL_UNKNOWN, CODE_NOT_INIT, 1, 2, ACK_STORED));
    // spare codes only pass at level unknown
    plan.push_back(plan_row(ACT_REPORT, 5, LVL_UNKNOWN, CODE_SPARE_HI, 0, 0, ACK_STORED));
    plan.push_back(plan_row(ACT_REPORT, 5, LVL_FAILED, CODE_SPARE_LO, 10, 10, ACK_REFUSED));
    plan.push_back(plan_row(ACT_REPORT, 6, LVL_UNKNOWN, CODE_STALE, 7000, 7000, ACK_STORED));
    plan.push_back(plan_row(ACT_REPORT, 7, LVL_UNKNOWN, CODE_TS_INVALID, 8000, 8000,
                            ACK_STORED));
    // snapshots: stamps in the future, fresh, stale, and time at both ends
    plan.push_back(plan_row(ACT_SNAPSHOT, 0, LVL_HEALTHY, CODE_NOT_INIT, 0, 5000, BY_MODEL));
    plan.push_back(plan_row(ACT_SNAPSHOT, 0, LVL_HEALTHY, CODE_NOT_INIT, 0, 20000, BY_MODEL));
    plan.push_back(plan_row(ACT_SNAPSHOT, 0, LVL_HEALTHY, CODE_NOT_INIT, 0, STAMP_MAX,
                            BY_MODEL));
    plan.push_back(plan_row(ACT_SNAPSHOT, 0, LVL_HEALTHY, CODE_NOT_INIT, 0, 0, BY_MODEL));
    foreach (plan[k])
      send_item(plan[k].it, plan[k].chk);

    for (p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: lim = '0;
        1: lim = STAMP_MAX;
        2: lim = {$urandom, $urandom};
        3: lim = STAMP_W'($urandom_range(1, 3000));
        default: lim = STALE_LIMIT_RESET;
      endcase
      set_stale_limit(lim);
      brisk = (p == 2);
      // one long output hold while items keep coming, so the table backs up
      if (p == 1)
        hold_rsp = 1'b1;
      // move time into the second quarter of the range
      if (p == 2)
        now_base = 64'h4000_0000_0000_0000 | STAMP_W'($urandom);
      for (k = 0; k < ITEMS_PER_PHASE; k++)
        send_item(draw_item(), BY_MODEL);
    end

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (faults == 0 && due_results.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  // Receiver: random stall per result, one long hold when asked.
  initial begin
    int gap;
    rsp_ch.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_rsp) begin
        hold_rsp = 1'b0;
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        gap = brisk ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
          rsp_ch.ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (!rsp_ch.valid);
    end
  end

  // Compares each result taken with the oldest one booked.
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      got.kind           = rsp_ch.kind;
      got.accepted       = rsp_ch.accepted;
      got.entry_index    = rsp_ch.entry_index;
      got.entry_level    = rsp_ch.entry_level;
      got.entry_code     = rsp_ch.entry_code;
      got.entry_stamp_ms = rsp_ch.entry_stamp_ms;
      got.overall_level  = rsp_ch.overall_level;
      got.last           = rsp_ch.last;
      if (due_results.size() == 0) begin
        faults++;
        if (faults <= MAX_SHOWN)
          $display("unexpected result: kind %0d idx %0d last %0d", got.kind,
                   got.entry_index, got.last);
      end else begin
        want = due_results.pop_front();
        if (got !== want) begin
          faults++;
          if (faults <= MAX_SHOWN) begin
            $display("mismatch exp: kind %0d acc %0d idx %0d lvl %0d code %0d stamp %h ovl %0d last %0d",
                     want.kind, want.accepted, want.entry_index, want.entry_level,
                     want.entry_code, want.entry_stamp_ms, want.overall_level, want.last);
            $display("         got: kind %0d acc %0d idx %0d lvl %0d code %0d stamp %h ovl %0d last %0d",
                     got.kind, got.accepted, got.entry_index, got.entry_level,
                     got.entry_code, got.entry_stamp_ms, got.overall_level, got.last);
          end
        end
      end
    end
  end

  // Watchdog: cycles in a row with no handshake on any channel.
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
        || (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
